// ===== rtl/pts_pkg.sv =====
// Shared types and constants for the periodic task scheduler.
// Depends on nothing; imported by the controller, the datapath and the top level.
`default_nettype none

package pts_pkg;

    // Field widths fixed by the item format.
    localparam int OP_W       = 2;
    localparam int SLOT_W     = 3;
    localparam int PERIOD_W   = 16;
    localparam int PEND_W     = 8;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;

    // The slot field reaches eight slots at most, so a pass never exceeds eight words.
    localparam int SLOT_REACH = 8;

    // Defaults for the top-level parameters.
    localparam int NUM_SLOTS_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    // Saturation ceiling of the pending-run count.
    localparam logic [PEND_W-1:0] PEND_MAX = 8'hFF;

    // Operation codes carried in s_tuser.
    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_ADD      = 2'd1,
        OP_DISPATCH = 2'd2
    } op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_TICK,
        ST_DISP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the accepted word and rewind the slot index
        logic add;       // write the latched slot
        logic tick;      // advance the slot under the index
        logic disp;      // emit the slot under the index and take one run
        logic idx_inc;   // step to the next slot
    } pts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_end;    // index is on the last slot of the table
        logic hit;       // slot under the index has runs due
        logic last_hit;  // ... and no higher slot has any
        logic out_busy;  // output register holds a word that is not being taken
    } pts_status_t;

endpackage

`default_nettype wire

// ===== rtl/periodic_task_scheduler.sv =====
// Periodic task scheduler: a table of prioritised task slots with tick, add and
// dispatch operations. A tick or a dispatch walks the slot index through the table,
// which holds at most eight slots, one slot per cycle through a single tick and
// dispatch unit; a dispatch waits on a due slot while the output register holds a
// word that m_tready has not taken. A new word is taken only once the previous one
// has finished its walk; the output register lets the next word enter while the
// final dispatched word still waits to be taken.
// Depends on pts_pkg, pts_ctrl and pts_datapath.
`default_nettype none

module periodic_task_scheduler
    import pts_pkg::*;
#(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // slot [2:0], period [18:3], zeros above
    input  wire logic [OP_W-1:0]       s_tuser,   // op [1:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // task_slot [2:0], zeros above
    output logic                       m_tlast
);

    pts_cmd_t          cmd;
    pts_status_t       status;
    logic [SLOT_W-1:0] m_slot;

    // Sequencing of each word through the table.
    pts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Slot table and output register.
    pts_datapath #(
        .NUM_SLOTS   (NUM_SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_slot   (s_tdata[SLOT_W-1:0]),
        .s_period (s_tdata[SLOT_W+PERIOD_W-1:SLOT_W]),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_slot   (m_slot),
        .m_last   (m_tlast)
    );

    assign m_tdata = M_TDATA_W'(m_slot);

endmodule

`default_nettype wire

// ===== rtl/pts_ctrl.sv =====
// Controller state machine of the periodic task scheduler.
// Depends on pts_pkg; drives pts_datapath through command and status structs.
`default_nettype none

module pts_ctrl
    import pts_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic [OP_W-1:0]  s_op,
    output logic                  s_tready,
    input  wire pts_status_t      status,
    output pts_cmd_t              cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands. No word is taken while reset is held.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.capture = 1'b1;
                    case (s_op)
                        OP_TICK:     state_next = ST_TICK;
                        OP_ADD:      state_next = ST_ADD;
                        OP_DISPATCH: state_next = ST_DISP;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                cmd.add    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_TICK: begin
                cmd.tick = 1'b1;
                if (status.at_end) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_DISP: begin
                if (status.hit) begin
                    // Wait for room in the output register before taking a run.
                    if (!status.out_busy) begin
                        cmd.disp = 1'b1;
                        if (status.last_hit) begin
                            state_next = ST_IDLE;
                        end else begin
                            cmd.idx_inc = 1'b1;
                        end
                    end
                end else if (status.at_end) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pts_datapath.sv =====
// Datapath of the periodic task scheduler: slot table, slot index and output register.
// Depends on pts_pkg; commanded by pts_ctrl.
`default_nettype none

module pts_datapath
    import pts_pkg::*;
#(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [SLOT_W-1:0]    s_slot,
    input  wire logic [PERIOD_W-1:0]  s_period,
    input  wire pts_cmd_t             cmd,
    output pts_status_t               status,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [SLOT_W-1:0]         m_slot,
    output logic                      m_last
);

    // Only slots the slot field can reach are ever filled.
    localparam int SCAN  = (NUM_SLOTS < SLOT_REACH) ? NUM_SLOTS : SLOT_REACH;
    localparam int IDX_W = (SCAN > 1) ? $clog2(SCAN) : 1;
    localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

    // Slot table; valid bits are the only reset part.
    logic                   valid_reg   [SCAN];
    logic [COUNT_WIDTH-1:0] period_reg  [SCAN];
    logic [COUNT_WIDTH-1:0] counter_reg [SCAN];
    logic [PEND_W-1:0]      pend_reg    [SCAN];

    logic [SLOT_W-1:0]      slot_reg;
    logic [COUNT_WIDTH-1:0] period_sat_reg;
    logic [COUNT_WIDTH-1:0] period_sat_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic                   out_last_reg;

    logic                   add_ok;
    logic [SCAN-1:0]        pend_mask;
    logic [SCAN-1:0]        above;
    logic [COUNT_WIDTH-1:0] cnt_cur;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic [PEND_W-1:0]      pend_cur;
    logic [PEND_W-1:0]      pend_tick_next;

    // Period saturated to the counter width.
    always_comb begin
        if (33'(s_period) > CNT_MAX) begin
            period_sat_next = CNT_MAX[COUNT_WIDTH-1:0];
        end else begin
            period_sat_next = COUNT_WIDTH'(s_period);
        end
    end

    // Latch the accepted word.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            slot_reg       <= s_slot;
            period_sat_reg <= period_sat_next;
        end
    end

    // Slot index: rewound on every new word, stepped by the controller.
    always_comb begin
        idx_next = idx_reg;
        if (cmd.capture) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    // Status for the controller.
    always_comb begin
        for (int i = 0; i < SCAN; i++) begin
            pend_mask[i] = valid_reg[i] && (pend_reg[i] != '0);
        end
        above           = pend_mask >> idx_reg;
        status.hit      = above[0];
        status.last_hit = above[0] && ((above >> 1) == '0);
        status.at_end   = (idx_reg == IDX_W'(SCAN - 1));
        status.out_busy = out_valid_reg && !m_tready;
    end

    // Tick update of the slot under the index.
    always_comb begin
        cnt_cur        = counter_reg[idx_reg];
        pend_cur       = pend_reg[idx_reg];
        pend_tick_next = pend_cur;
        if (cnt_cur == '0) begin
            cnt_next = period_reg[idx_reg];
        end else begin
            cnt_next = cnt_cur - COUNT_WIDTH'(1);
            if ((cnt_next == '0) && (pend_cur != PEND_MAX)) begin
                pend_tick_next = pend_cur + PEND_W'(1);
            end
        end
    end

    assign add_ok = ({1'b0, slot_reg} < (SLOT_W + 1)'(SCAN));

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SCAN; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (cmd.add && add_ok) begin
            valid_reg[slot_reg[IDX_W-1:0]] <= 1'b1;
        end
    end

    // Period, counter and pending-run count.
    always_ff @(posedge aclk) begin
        if (cmd.add && add_ok) begin
            period_reg[slot_reg[IDX_W-1:0]]  <= period_sat_reg;
            counter_reg[slot_reg[IDX_W-1:0]] <= period_sat_reg;
            pend_reg[slot_reg[IDX_W-1:0]]    <= '0;
        end else if (cmd.tick && valid_reg[idx_reg]) begin
            counter_reg[idx_reg] <= cnt_next;
            pend_reg[idx_reg]    <= pend_tick_next;
        end else if (cmd.disp) begin
            pend_reg[idx_reg] <= pend_cur - PEND_W'(1);
        end
    end

    // Output register.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.disp) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.disp) begin
            out_slot_reg <= SLOT_W'(idx_reg);
            out_last_reg <= status.last_hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_slot   = out_slot_reg;
    assign m_last   = out_last_reg;

    // A run is taken only from a slot that has one, and only into a free output register.
    a_disp_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.disp |-> (status.hit && !status.out_busy))
        else $error("dispatch word issued without a due run or without room");

    // Table writes and table walks never overlap.
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.add && (cmd.tick || cmd.disp)) && !(cmd.tick && cmd.disp))
        else $error("conflicting table commands");

    // The final word of a pass ends the pass.
    a_last_ends_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.disp && status.last_hit) |=> !cmd.disp)
        else $error("dispatch continued after the final word");

    // A word loaded into the output register is offered in the next cycle.
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.disp |=> (m_tvalid && (m_slot == $past(SLOT_W'(idx_reg)))))
        else $error("dispatched word not presented");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the periodic task scheduler: a directed table and random
// traffic, checked against typed expectations or a behavioural copy of the slot table.
// Depends on pts_pkg and periodic_task_scheduler.
`timescale 1ns / 100ps

module tb_top;
    import pts_pkg::*;

    localparam int TB_SLOTS       = NUM_SLOTS_DEF;
    localparam int RANDOM_WORDS   = 184;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 30;
    localparam int PRINT_CAP      = 20;

    // The one operation code the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One row of stimulus; typed rows carry their own expectation (none or one run).
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period;
        logic                typed;
        logic                typed_hit;
        logic [SLOT_W-1:0]   typed_slot;
    } stim_row_t;

    // One dispatched run: the slot to execute and the end-of-pass mark.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              last;
    } run_t;

    localparam int PLAN_LEN = 26;
    stim_row_t plan [PLAN_LEN] = '{
        '{OP_DISPATCH, 3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},  // empty table after reset
        '{OP_TICK,     3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
        '{OP_ADD,      3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},  // period zero never fires
        '{OP_TICK,     3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
        '{OP_TICK,     3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
        '{OP_DISPATCH, 3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
        '{OP_ADD,      3'd7, 16'h0001, 1'b1, 1'b0, 3'd0},
        '{OP_TICK,     3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
        '{OP_DISPATCH, 3'd0, 16'h0000, 1'b1, 1'b1, 3'd7},  // highest slot, single run
        '{OP_ADD,      3'd3, 16'hFFFF, 1'b1, 1'b0, 3'd0},  // widest period
        '{OP_ADD,      3'd5, 16'h0002, 1'b1, 1'b0, 3'd0},
        '{OP_TICK,     3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
        '{OP_TICK,     3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
        '{OP_DISPATCH, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},
        '{OP_UNUSED,   3'd6, 16'hA5A5, 1'b1, 1'b0, 3'd0},  // unused code is ignored
        '{OP_DISPATCH, 3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},  // nothing due
        '{OP_ADD,      3'd1, 16'h0001, 1'b1, 1'b0, 3'd0},
        '{OP_ADD,      3'd2, 16'h0001, 1'b1, 1'b0, 3'd0},
        '{OP_ADD,      3'd4, 16'h0001, 1'b1, 1'b0, 3'd0},
        '{OP_ADD,      3'd6, 16'h0001, 1'b1, 1'b0, 3'd0},
        '{OP_TICK,     3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
        '{OP_TICK,     3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
        '{OP_DISPATCH, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0},  // many slots in one pass
        '{OP_TICK,     3'd0, 16'h0000, 1'b1, 1'b0, 3'd0},
        '{OP_ADD,      3'd1, 16'h0003, 1'b1, 1'b0, 3'd0},  // re-add drops the due run
        '{OP_DISPATCH, 3'd0, 16'h0000, 1'b0, 1'b0, 3'd0}
    };

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // Shadow copy of the slot table.
    logic                sched_valid  [TB_SLOTS];
    logic [PERIOD_W-1:0] sched_period [TB_SLOTS];
    logic [PERIOD_W-1:0] sched_count  [TB_SLOTS];
    logic [PEND_W-1:0]   sched_due    [TB_SLOTS];

    run_t pass_runs[$];   // runs produced by the word just accepted
    run_t due_runs[$];    // runs still awaited from the block

    int errors      = 0;
    int runs_seen   = 0;
    int quiet       = 0;
    int rx_hold     = 0;
    int cyc         = 0;
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;
    int op_seen [4] = '{0, 0, 0, 0};

    periodic_task_scheduler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Small periods keep slots firing; the odd wide one exercises the upper bits.
    function automatic logic [PERIOD_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return PERIOD_W'($urandom_range(0, 4));
        if (r < 90) return PERIOD_W'($urandom_range(5, 40));
        return PERIOD_W'($urandom);
    endfunction

    task automatic report_mismatch(string msg);
        if (errors < PRINT_CAP) $display("tb_top: mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Applies one accepted word to the shadow table and collects the runs it dispatches.
    task automatic apply_word(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                              logic [PERIOD_W-1:0] period);
        run_t tail;
        pass_runs.delete();
        case (op)
            OP_TICK: begin
                for (int i = 0; i < TB_SLOTS; i++) begin
                    if (sched_valid[i]) begin
                        if (sched_count[i] == '0) begin
                            sched_count[i] = sched_period[i];
                        end else begin
                            sched_count[i] = sched_count[i] - 1'b1;
                            if (sched_count[i] == '0 && sched_due[i] != PEND_MAX)
                                sched_due[i] = sched_due[i] + 1'b1;
                        end
                    end
                end
            end
            OP_ADD: begin
                sched_valid[slot]  = 1'b1;
                sched_period[slot] = period;
                sched_count[slot]  = period;
                sched_due[slot]    = '0;
            end
            OP_DISPATCH: begin
                for (int i = 0; i < TB_SLOTS; i++) begin
                    if (sched_valid[i] && sched_due[i] != '0) begin
                        sched_due[i] = sched_due[i] - 1'b1;
                        pass_runs.push_back({i[SLOT_W-1:0], 1'b0});
                    end
                end
                if (pass_runs.size() != 0) begin
                    tail = pass_runs.pop_back();
                    tail.last = 1'b1;
                    pass_runs.push_back(tail);
                end
            end
            default: begin
                // Unused code: nothing changes.
            end
        endcase
    endtask

    // Presents one word, waits for it to be taken, then records what it should produce.
    task automatic send_word(stim_row_t row);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= row.op;
        s_tdata  <= {{(S_TDATA_W - PERIOD_W - SLOT_W){1'b0}}, row.period, row.slot};
        do @(posedge aclk); while (!s_tready);
        apply_word(row.op, row.slot, row.period);
        if (row.typed) begin
            if (row.typed_hit) due_runs.push_back({row.typed_slot, 1'b1});
        end else begin
            foreach (pass_runs[k]) due_runs.push_back(pass_runs[k]);
        end
        op_seen[row.op]++;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Receiver back-pressure, with occasional stretches of continuous readiness.
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc % 200 == 0) rx_steady <= ($urandom_range(0, 3) == 0);
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_steady || $urandom_range(0, 99) < 65) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            rx_hold  <= pick_gap();
        end
    end

    // Result checking against the oldest awaited run.
    always @(posedge aclk) begin
        run_t want;
        if (aresetn && m_tvalid && m_tready) begin
            runs_seen++;
            if (due_runs.size() == 0) begin
                report_mismatch($sformatf("unexpected word, slot %0d", m_tdata[SLOT_W-1:0]));
            end else begin
                want = due_runs.pop_front();
                if (m_tdata[SLOT_W-1:0] !== want.slot)
                    report_mismatch($sformatf("task_slot %0d, expected %0d",
                                              m_tdata[SLOT_W-1:0], want.slot));
                if (m_tdata[M_TDATA_W-1:SLOT_W] !== '0)
                    report_mismatch($sformatf("padding bits %0h not zero",
                                              m_tdata[M_TDATA_W-1:SLOT_W]));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("tlast %0b, expected %0b", m_tlast, want.last));
            end
        end
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb_top: watchdog expired with %0d runs outstanding", due_runs.size());
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        stim_row_t row;
        int r;
        int drain;

        for (int i = 0; i < TB_SLOTS; i++) begin
            sched_valid[i]  = 1'b0;
            sched_period[i] = '0;
            sched_count[i]  = '0;
            sched_due[i]    = '0;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table.
        for (int n = 0; n < PLAN_LEN; n++) send_word(plan[n]);

        // Random traffic, biased towards ticks and dispatches on a populated table.
        row = '0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 32 == 0) tx_steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            row.slot   = SLOT_W'($urandom_range(0, TB_SLOTS - 1));
            row.period = PERIOD_W'($urandom);
            if (r < 12) begin
                row.op     = OP_ADD;
                row.period = pick_period();
            end else if (r < 62) begin
                row.op = OP_TICK;
            end else if (r < 95) begin
                row.op = OP_DISPATCH;
            end else begin
                row.op = OP_UNUSED;
            end
            send_word(row);
        end

        s_tvalid <= 1'b0;
        while (due_runs.size() != 0) @(posedge aclk);
        for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge aclk);

        $display("tb_top: %0d words in (%0d tick, %0d add, %0d dispatch, %0d unused code)",
                 op_seen[OP_TICK] + op_seen[OP_ADD] + op_seen[OP_DISPATCH] + op_seen[OP_UNUSED],
                 op_seen[OP_TICK], op_seen[OP_ADD], op_seen[OP_DISPATCH], op_seen[OP_UNUSED]);
        $display("tb_top: %0d dispatched runs compared, %0d mismatches", runs_seen, errors);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
